// ===== sv/fgc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fgc_pkg: shared types and constants
// Field widths, register indexes, opcodes and the command and status words
// passed between the gated frequency counter sequencer and its datapath.
// ----------------------------------------------------------------------------
package fgc_pkg;

  localparam int OPC_W         = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int DIV_W         = 16;
  localparam int CLK_W         = 28;
  localparam int PER_W         = 32;
  localparam int FRAC_W        = 8;
  localparam int FREQ_W        = 48;
  localparam int CUM_W         = 32;
  localparam int MUL_W         = 32;
  localparam int MA_W          = 2 * MUL_W;
  localparam int DEN_LIM_W     = 64;
  localparam int PORT_SAMPLE_W = 16;

  localparam logic [PORT_SAMPLE_W-1:0] SAMPLE_PORT_MASK = 16'hFFFF;

  localparam logic [DIV_W-1:0] DIV_RST = 16'd1;
  localparam logic [CLK_W-1:0] CLK_RST = 28'd72000000;
  localparam logic [PER_W-1:0] PER_RST = 32'd72000;

  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd2;

  typedef enum logic [OPC_W-1:0] {
    OP_TICK       = 3'd0,
    OP_ARM        = 3'd1,
    OP_STOP       = 3'd2,
    OP_SNAP_REQ   = 3'd3,
    OP_READ_SNAP  = 3'd4,
    OP_READ_FINAL = 3'd5
  } opcode_t;

  // product being formed by the shared multiplier
  typedef enum logic [1:0] {
    PRD_PA  = 2'd0,
    PRD_NUM = 2'd1,
    PRD_DEN = 2'd2
  } prod_t;

  typedef struct packed {
    logic  load;
    logic  mul;
    logic  add;
    logic  xfer;
    logic  norm;
    logic  div;
    logic  chunk;
    prod_t idx;
  } arith_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic den_big;
  } arith_sts_t;

  typedef struct packed {
    logic             measuring;
    logic             snapshot_ready;
    logic             read_go;
    logic [CUM_W-1:0] cumulative;
  } trk_sts_t;

  typedef struct packed {
    logic load;
    logic valid;
  } emit_t;

endpackage
`default_nettype wire

// ===== sv/fgc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fgc_if: word channels
// Event channel into the counter and result channel out of it.
// ----------------------------------------------------------------------------
interface fgc_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                        valid;
  logic                        ready;
  logic [fgc_pkg::OPC_W-1:0]   opcode;
  logic [SAMPLE_WIDTH-1:0]     counter_sample;

  modport source (output valid, output opcode, output counter_sample, input ready);
  modport sink   (input valid, input opcode, input counter_sample, output ready);
endinterface

interface fgc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        freq_valid;
  logic [fgc_pkg::FREQ_W-1:0]  frequency_q8;
  logic [fgc_pkg::CUM_W-1:0]   ticks_seen;
  logic                        measuring;
  logic                        snapshot_ready;

  modport source (output valid, output freq_valid, output frequency_q8,
                  output ticks_seen, output measuring, output snapshot_ready,
                  input ready);
  modport sink   (input valid, input freq_valid, input frequency_q8,
                  input ticks_seen, input measuring, input snapshot_ready,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/gated_frequency_counter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gated_frequency_counter_core: gated frequency counter
// Tracks timebase ticks and pulse counter samples and reports the measured
// frequency, pulses*divider*clock/(period*ticks), in unsigned Q40.8 hertz.
//
//   channel  dir  handshake      contents
//   in_ch    in   valid/ready    opcode, counter_sample
//   out_ch   out  valid/ready    freq_valid, frequency_q8, ticks_seen,
//                                measuring, snapshot_ready
//   cfg      in   cfg_we         cfg_index, cfg_data (no read-back)
//
// One word in flight. A non-reading word is emitted through S_POST. A
// reading runs 12 multiplier steps, s denominator shifts (ACC_WIDTH > 32
// only) and one restoring divider step per numerator bit (ACC_WIDTH + 52
// numerator bits).
// Reset: synchronous, clears modes, accumulators and tick count; config
// returns to divider 1, clock 72 MHz, period 72000.
// A stalled result sits in the output register; the next word is taken
// once that register is free or emptied in the same cycle.
// ----------------------------------------------------------------------------
module gated_frequency_counter_core #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH    = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  fgc_in_if.sink                                 in_ch,
  fgc_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [fgc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fgc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [fgc_pkg::DIV_W-1:0]  divider_ratio;
  logic [fgc_pkg::CLK_W-1:0]  clock_rate_hz;
  logic [fgc_pkg::PER_W-1:0]  tick_period_cycles;

  logic                       take;
  logic                       out_free;
  logic [SAMPLE_WIDTH-1:0]    sample;
  logic [ACC_WIDTH-1:0]       pulses;
  logic [ACC_WIDTH-1:0]       ticks;
  logic [fgc_pkg::FREQ_W-1:0] freq;
  fgc_pkg::trk_sts_t          tsts;
  fgc_pkg::arith_sts_t        asts;
  fgc_pkg::arith_cmd_t        cmd;
  fgc_pkg::emit_t             emit;

  assign sample   = in_ch.counter_sample & SAMPLE_WIDTH'(fgc_pkg::SAMPLE_PORT_MASK);
  assign take     = in_ch.valid && in_ch.ready;
  assign out_free = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_ratio      <= fgc_pkg::DIV_RST;
      clock_rate_hz      <= fgc_pkg::CLK_RST;
      tick_period_cycles <= fgc_pkg::PER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fgc_pkg::REG_DIVIDER: divider_ratio      <= cfg_data[fgc_pkg::DIV_W-1:0];
        fgc_pkg::REG_CLOCK:   clock_rate_hz      <= cfg_data[fgc_pkg::CLK_W-1:0];
        fgc_pkg::REG_PERIOD:  tick_period_cycles <= cfg_data[fgc_pkg::PER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fgc_track #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_track (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .opcode (in_ch.opcode),
    .sample (sample),
    .sts    (tsts),
    .pulses (pulses),
    .ticks  (ticks)
  );

  fgc_ctrl #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .read_go  (tsts.read_go),
    .asts     (asts),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .emit     (emit)
  );

  fgc_arith #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_arith (
    .clk        (clk),
    .cmd        (cmd),
    .divider    (divider_ratio),
    .clock_rate (clock_rate_hz),
    .period     (tick_period_cycles),
    .pulses     (pulses),
    .ticks      (ticks),
    .sts        (asts),
    .freq       (freq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (emit.load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_ch.freq_valid     <= emit.valid;
      out_ch.frequency_q8   <= emit.valid ? freq : '0;
      out_ch.ticks_seen     <= tsts.cumulative;
      out_ch.measuring      <= tsts.measuring;
      out_ch.snapshot_ready <= tsts.snapshot_ready;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fgc_track.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fgc_track: measurement state
// Count and read modes, pulse and tick accumulators, snapshot and the
// cumulative tick count; selects the operands for a reading.
// ----------------------------------------------------------------------------
module fgc_track #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH    = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          take,
  input  wire logic [fgc_pkg::OPC_W-1:0]     opcode,
  input  wire logic [SAMPLE_WIDTH-1:0]       sample,
  output fgc_pkg::trk_sts_t                  sts,
  output logic      [ACC_WIDTH-1:0]          pulses,
  output logic      [ACC_WIDTH-1:0]          ticks
);

  typedef enum logic [1:0] {CM_IDLE, CM_ARMED, CM_MEAS} count_mode_t;
  typedef enum logic [1:0] {RM_IDLE, RM_WAIT, RM_READY} read_mode_t;

  count_mode_t                 count_mode;
  read_mode_t                  read_mode;
  logic [SAMPLE_WIDTH-1:0]     last_sample;
  logic [ACC_WIDTH-1:0]        pulse_total;
  logic [ACC_WIDTH-1:0]        tick_total;
  logic [ACC_WIDTH-1:0]        snap_pulses;
  logic [ACC_WIDTH-1:0]        snap_ticks;
  logic [fgc_pkg::CUM_W-1:0]   tick_cumulative;

  logic [SAMPLE_WIDTH-1:0]     diff;
  logic [ACC_WIDTH-1:0]        pulse_next;
  logic [ACC_WIDTH-1:0]        tick_next;
  fgc_pkg::opcode_t            op;

  assign op         = fgc_pkg::opcode_t'(opcode);
  assign diff       = sample - last_sample;
  assign pulse_next = pulse_total + ACC_WIDTH'(diff);
  assign tick_next  = tick_total + ACC_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count_mode      <= CM_IDLE;
      read_mode       <= RM_IDLE;
      last_sample     <= '0;
      pulse_total     <= '0;
      tick_total      <= '0;
      snap_pulses     <= '0;
      snap_ticks      <= '0;
      tick_cumulative <= '0;
    end else if (take) begin
      case (op)
        fgc_pkg::OP_TICK: begin
          tick_cumulative <= tick_cumulative + fgc_pkg::CUM_W'(1);
          if (count_mode == CM_MEAS) begin
            tick_total  <= tick_next;
            pulse_total <= pulse_next;
            last_sample <= sample;
            if (read_mode == RM_WAIT) begin
              snap_ticks  <= tick_next;
              snap_pulses <= pulse_next;
              read_mode   <= RM_READY;
            end
          end else if (count_mode == CM_ARMED) begin
            last_sample <= sample;
            pulse_total <= '0;
            tick_total  <= '0;
            count_mode  <= CM_MEAS;
          end
        end
        fgc_pkg::OP_ARM: begin
          read_mode  <= RM_IDLE;
          count_mode <= CM_ARMED;
        end
        fgc_pkg::OP_STOP: begin
          count_mode <= CM_IDLE;
        end
        fgc_pkg::OP_SNAP_REQ: begin
          snap_pulses <= '0;
          snap_ticks  <= '0;
          read_mode   <= RM_WAIT;
        end
        fgc_pkg::OP_READ_FINAL: begin
          if (count_mode == CM_MEAS) begin
            count_mode <= CM_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    sts.measuring      = (count_mode == CM_MEAS);
    sts.snapshot_ready = (read_mode == RM_READY);
    sts.cumulative     = tick_cumulative;
    sts.read_go        = ((op == fgc_pkg::OP_READ_SNAP) && (read_mode == RM_READY)) ||
                         ((op == fgc_pkg::OP_READ_FINAL) && (count_mode == CM_MEAS) &&
                          (tick_total != '0));
    pulses = (op == fgc_pkg::OP_READ_SNAP) ? snap_pulses : pulse_total;
    ticks  = (op == fgc_pkg::OP_READ_SNAP) ? snap_ticks  : tick_total;
  end

endmodule
`default_nettype wire

// ===== sv/fgc_arith.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fgc_arith: frequency datapath
// Shared 32x32 multiplier forming numerator and denominator in 32-bit
// chunks, denominator normalization, and a restoring divider giving one
// quotient bit per step with saturation to the Q40.8 range.
// ----------------------------------------------------------------------------
module fgc_arith #(
  parameter int ACC_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire fgc_pkg::arith_cmd_t          cmd,
  input  wire logic [fgc_pkg::DIV_W-1:0]    divider,
  input  wire logic [fgc_pkg::CLK_W-1:0]    clock_rate,
  input  wire logic [fgc_pkg::PER_W-1:0]    period,
  input  wire logic [ACC_WIDTH-1:0]         pulses,
  input  wire logic [ACC_WIDTH-1:0]         ticks,
  output fgc_pkg::arith_sts_t               sts,
  output logic      [fgc_pkg::FREQ_W-1:0]   freq
);

  localparam int PW    = ACC_WIDTH + fgc_pkg::DIV_W + fgc_pkg::CLK_W;
  localparam int NUM_W = PW + fgc_pkg::FRAC_W;
  localparam int DEN_W = ACC_WIDTH + fgc_pkg::PER_W;
  localparam int DW    = (DEN_W > fgc_pkg::DEN_LIM_W) ? fgc_pkg::DEN_LIM_W : DEN_W;

  logic [fgc_pkg::MA_W-1:0]   ma;
  logic [fgc_pkg::MUL_W-1:0]  mb;
  logic [fgc_pkg::MA_W-1:0]   pp;
  logic [PW-1:0]              prod;
  logic [ACC_WIDTH-1:0]       opt;
  logic [NUM_W-1:0]           num;
  logic [DEN_W-1:0]           den;
  logic [DW-1:0]              rem;
  logic [fgc_pkg::FREQ_W-1:0] quo;
  logic                       ovf;

  logic [DW-1:0]              d;
  logic [DW:0]                r2;
  logic [DW:0]                r2_sub;
  logic                       ge;
  logic [DW-1:0]              rem_next;

  assign d        = den[DW-1:0];
  assign r2       = {rem, num[NUM_W-1]};
  assign r2_sub   = r2 - {1'b0, d};
  assign ge       = (r2 >= {1'b0, d});
  assign rem_next = ge ? r2_sub[DW-1:0] : r2[DW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ma   <= fgc_pkg::MA_W'(pulses);
      mb   <= fgc_pkg::MUL_W'(divider);
      opt  <= ticks;
      prod <= '0;
      rem  <= '0;
      quo  <= '0;
      ovf  <= 1'b0;
    end else if (cmd.mul) begin
      pp <= ma[fgc_pkg::MUL_W-1:0] * mb;
      ma <= ma >> fgc_pkg::MUL_W;
    end else if (cmd.add) begin
      prod <= prod + (cmd.chunk ? PW'({pp, {fgc_pkg::MUL_W{1'b0}}}) : PW'(pp));
    end else if (cmd.xfer) begin
      case (cmd.idx)
        fgc_pkg::PRD_PA: begin
          ma   <= fgc_pkg::MA_W'(prod);
          mb   <= fgc_pkg::MUL_W'(clock_rate);
          prod <= '0;
        end
        fgc_pkg::PRD_NUM: begin
          num  <= NUM_W'(prod) << fgc_pkg::FRAC_W;
          ma   <= fgc_pkg::MA_W'(opt);
          mb   <= period;
          prod <= '0;
        end
        fgc_pkg::PRD_DEN: begin
          den <= DEN_W'(prod);
        end
        default: begin
        end
      endcase
    end else if (cmd.norm) begin
      den <= den >> 1;
      num <= num >> 1;
    end else if (cmd.div) begin
      num <= num << 1;
      rem <= rem_next;
      quo <= {quo[fgc_pkg::FREQ_W-2:0], ge};
      ovf <= ovf | quo[fgc_pkg::FREQ_W-1];
    end
  end

  assign sts.den_zero = (den == '0);
  assign sts.den_big  = |(den >> fgc_pkg::DEN_LIM_W);
  assign freq         = ovf ? '1 : quo;

endmodule
`default_nettype wire

// ===== sv/fgc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fgc_ctrl: sequencer
// Accepts one word at a time and steps the datapath through the three
// products, normalization and division of a reading.
// ----------------------------------------------------------------------------
module fgc_ctrl #(
  parameter int ACC_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 out_free,
  input  wire logic                 read_go,
  input  wire fgc_pkg::arith_sts_t  asts,
  output logic                      in_ready,
  output fgc_pkg::arith_cmd_t       cmd,
  output fgc_pkg::emit_t            emit
);

  localparam int NUM_W = ACC_WIDTH + fgc_pkg::DIV_W + fgc_pkg::CLK_W + fgc_pkg::FRAC_W;
  localparam int CNT_W = $clog2(NUM_W);

  typedef enum logic [2:0] {
    S_IDLE, S_POST, S_MUL, S_XFER, S_NORM, S_DIV, S_DONE
  } state_t;

  state_t          state;
  logic [1:0]      step;
  fgc_pkg::prod_t  idx;
  logic [CNT_W-1:0] dcnt;
  logic            take;

  assign in_ready = (state == S_IDLE) && out_free;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      idx   <= fgc_pkg::PRD_PA;
      dcnt  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            step  <= '0;
            idx   <= fgc_pkg::PRD_PA;
            state <= read_go ? S_MUL : S_POST;
          end
        end
        S_POST: state <= S_IDLE;
        S_MUL: begin
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= S_XFER;
          end
        end
        S_XFER: begin
          case (idx)
            fgc_pkg::PRD_PA: begin
              idx   <= fgc_pkg::PRD_NUM;
              state <= S_MUL;
            end
            fgc_pkg::PRD_NUM: begin
              idx   <= fgc_pkg::PRD_DEN;
              state <= S_MUL;
            end
            default: state <= S_NORM;
          endcase
        end
        S_NORM: begin
          if (asts.den_zero) begin
            state <= S_DONE;
          end else if (!asts.den_big) begin
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          dcnt <= dcnt + CNT_W'(1);
          if (dcnt == CNT_W'(NUM_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.idx   = idx;
    cmd.chunk = step[1];
    case (state)
      S_IDLE: cmd.load = take && read_go;
      S_MUL: begin
        cmd.mul = !step[0];
        cmd.add = step[0];
      end
      S_XFER: cmd.xfer = 1'b1;
      S_NORM: cmd.norm = !asts.den_zero && asts.den_big;
      S_DIV:  cmd.div  = 1'b1;
      default: begin
      end
    endcase
    emit.load  = (state == S_POST) || (state == S_DONE);
    emit.valid = (state == S_DONE) && !asts.den_zero;
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit.load |-> out_free)
    else $error("result loaded over a pending word");

  a_plain_word: assert property (@(posedge clk) disable iff (rst)
    (take && !read_go) |=> (emit.load && !emit.valid))
    else $error("non-computing word did not emit next cycle");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("input accepted while busy");

  a_done_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> ($past(state) == S_DIV || $past(state) == S_NORM))
    else $error("reading finished without division");

endmodule
`default_nettype wire
